// ===== sv/rgb_pixel_filter_with_sobel_top_macros.svh =====
// Assertion macros shared by the pixel filter RTL.
`ifndef RGB_PIXEL_FILTER_WITH_SOBEL_TOP_MACROS_SVH
`define RGB_PIXEL_FILTER_WITH_SOBEL_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RPFS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RPFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rpfs_pkg.sv =====
// Package with constants, types and helpers of the RGB pixel filter.
`default_nettype none
package rpfs_pkg;

  localparam int PIX_W       = 8;
  localparam int COORD_W     = 11;
  localparam int CFG_W       = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int MODE_W      = 3;
  localparam int RES_N       = 4;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 48;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam int LUMA_R = 77;
  localparam int LUMA_G = 150;
  localparam int LUMA_B = 29;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  localparam logic [MODE_W-1:0] MODE_COPY  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RED   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_GREEN = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BLUE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_GRAY  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_BIN   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SOBEL = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd3;

  localparam logic [MODE_W-1:0] RST_MODE   = MODE_GRAY;
  localparam logic [PIX_W-1:0]  RST_THRESH = 8'd128;
  localparam logic [CFG_W-1:0]  RST_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0]  RST_HEIGHT = 12'd480;

  // Result slots of one pixel, emitted from the lowest bit up.
  localparam logic [RES_N-1:0] RES_MAIN   = 4'b0001;
  localparam logic [RES_N-1:0] RES_LEFT   = 4'b0010;
  localparam logic [RES_N-1:0] RES_UP     = 4'b0100;
  localparam logic [RES_N-1:0] RES_CORNER = 4'b1000;

  typedef struct packed {
    logic [PIX_W-1:0]   red;
    logic [PIX_W-1:0]   green;
    logic [PIX_W-1:0]   blue;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               shifted;
    logic [RES_N-1:0]   mask;
    logic               eof;
  } rpfs_res_t;

  function automatic logic [PIX_W-1:0] luma_of(input logic [PIX_W-1:0] r,
                                               input logic [PIX_W-1:0] g,
                                               input logic [PIX_W-1:0] b);
    logic [15:0] sum;
    sum = 16'(LUMA_R * r + LUMA_G * g + LUMA_B * b);
    return sum[15:8];
  endfunction

endpackage
`default_nettype wire

// ===== sv/rgb_pixel_filter_with_sobel_top.sv =====
// Top level of the RGB pixel filter with gray, binary and Sobel edge modes.
//
// Pixels enter in raster order on the slave stream, one word per pixel, and
// filtered words leave on the master stream with their column and row.
// Configuration is written through a plain port (mode, threshold, width,
// height) only while the block is idle, a rule for the user that the block
// does not enforce; it takes effect for the next pixel. Each accepted pixel
// reads both luma line stores at its column and writes its own luma in the
// same cycle; stage 1 shifts the 3x3 window with the registered read data
// and forms the result. Throughput: one pixel per cycle while each pixel
// gives one word and the receiver is ready. In Sobel mode a pixel gives
// zero to four words (row and frame edges); the output stage sends one word
// per cycle while the receiver is ready, so a pixel with more than one word
// holds the input until its last word is sent. Sobel words lag by one row
// and one column. When the receiver stalls, the output word holds and the
// input keeps accepting until the single internal stage is full. Reset
// loads the register defaults and clears the counters, the window and the
// stages; the line stores are not cleared and need no clearing pass.
`default_nettype none
`include "rgb_pixel_filter_with_sobel_top_macros.svh"
module rgb_pixel_filter_with_sobel_top #(
  parameter int MAX_WIDTH  = rpfs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rpfs_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rpfs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rpfs_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // in_red[7:0], in_green[15:8], in_blue[23:16]
  input  logic [rpfs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], out_col[34:24],
  // out_row[45:35], zero pad
  output logic [rpfs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tlast,   // end_of_frame
  output logic                             m_axis_tuser    // last_of_item
);
  import rpfs_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int RIW = RW + 1;

  // Configuration registers.
  logic [MODE_W-1:0] mode_q;
  logic [PIX_W-1:0]  thr_q;
  logic [CFG_W-1:0]  fw_q;
  logic [CFG_W-1:0]  fh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= RST_MODE;
      thr_q  <= RST_THRESH;
      fw_q   <= RST_WIDTH;
      fh_q   <= RST_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:   mode_q <= cfg_data_i[MODE_W-1:0];
        REG_THRESH: thr_q  <= cfg_data_i[PIX_W-1:0];
        REG_WIDTH:  fw_q   <= cfg_data_i;
        REG_HEIGHT: fh_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Frame size in use, clamped to 1..MAX.
  logic [WW-1:0] w;
  logic [HW-1:0] h;

  always_comb begin
    if (fw_q == '0) begin
      w = WW'(1);
    end else if (32'(fw_q) > 32'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(fw_q);
    end
    if (fh_q == '0) begin
      h = HW'(1);
    end else if (32'(fh_q) > 32'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(fh_q);
    end
  end

  // Input side: position of the incoming pixel and line store access.
  logic [CW-1:0]    col_q, col_d;
  logic [RW-1:0]    row_q, row_d;
  logic [RIW-1:0]   row_inc;
  logic [CW-1:0]    x0;
  logic [RW-1:0]    y0;
  logic             lc0, lr0;
  logic             wrap_col;
  logic             acc;
  logic [PIX_W-1:0] in_r, in_g, in_b, luma0;

  assign in_r  = s_axis_tdata[7:0];
  assign in_g  = s_axis_tdata[15:8];
  assign in_b  = s_axis_tdata[23:16];
  assign luma0 = luma_of(in_r, in_g, in_b);

  always_comb begin
    wrap_col = (WW'(col_q) >= w);
    row_inc  = {1'b0, row_q} + (wrap_col ? RIW'(1) : RIW'(0));
    x0       = wrap_col ? '0 : col_q;
    y0       = (row_inc >= RIW'(h)) ? '0 : row_inc[RW-1:0];
    lc0      = (WW'(x0) == w - WW'(1));
    lr0      = (HW'(y0) == h - HW'(1));
    if (lc0) begin
      col_d = '0;
      row_d = lr0 ? '0 : y0 + RW'(1);
    end else begin
      col_d = x0 + CW'(1);
      row_d = y0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  logic [PIX_W-1:0] bank0_rd, bank1_rd;

  rpfs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line0 (
    .clk_i   (clk_i),
    .we_i    (acc && !y0[0]),
    .waddr_i (x0),
    .wdata_i (luma0),
    .re_i    (acc),
    .raddr_i (x0),
    .rdata_o (bank0_rd)
  );

  rpfs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line1 (
    .clk_i   (clk_i),
    .we_i    (acc && y0[0]),
    .waddr_i (x0),
    .wdata_i (luma0),
    .re_i    (acc),
    .raddr_i (x0),
    .rdata_o (bank1_rd)
  );

  // Stage 1: line data is back; shift the window and form the result.
  logic             s1_v_q, s1_v_d;
  logic [CW-1:0]    s1_x_q;
  logic [RW-1:0]    s1_y_q;
  logic             s1_lc_q, s1_lr_q;
  logic [PIX_W-1:0] s1_luma_q, s1_r_q, s1_g_q, s1_b_q;
  logic             s1_adv;
  logic             emit_free;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_x_q    <= x0;
      s1_y_q    <= y0;
      s1_lc_q   <= lc0;
      s1_lr_q   <= lr0;
      s1_luma_q <= luma0;
      s1_r_q    <= in_r;
      s1_g_q    <= in_g;
      s1_b_q    <= in_b;
    end
  end

  logic [PIX_W-1:0] win_q [9];
  logic [PIX_W-1:0] win_n [9];
  logic [PIX_W-1:0] top, mid;

  assign top = s1_y_q[0] ? bank1_rd : bank0_rd;
  assign mid = s1_y_q[0] ? bank0_rd : bank1_rd;

  always_comb begin
    win_n[0] = win_q[1];
    win_n[1] = win_q[2];
    win_n[2] = top;
    win_n[3] = win_q[4];
    win_n[4] = win_q[5];
    win_n[5] = mid;
    win_n[6] = win_q[7];
    win_n[7] = win_q[8];
    win_n[8] = s1_luma_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_adv) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= win_n[i];
      end
    end
  end

  logic [9:0]       gx_p, gx_m, gy_p, gy_m;
  logic [10:0]      gx, gy;
  logic [9:0]       ax, ay;
  logic [10:0]      mag;
  logic [PIX_W-1:0] sobel;

  always_comb begin
    gx_p  = {2'b00, win_n[2]} + {1'b0, win_n[5], 1'b0} + {2'b00, win_n[8]};
    gx_m  = {2'b00, win_n[0]} + {1'b0, win_n[3], 1'b0} + {2'b00, win_n[6]};
    gy_p  = {2'b00, win_n[6]} + {1'b0, win_n[7], 1'b0} + {2'b00, win_n[8]};
    gy_m  = {2'b00, win_n[0]} + {1'b0, win_n[1], 1'b0} + {2'b00, win_n[2]};
    gx    = {1'b0, gx_p} - {1'b0, gx_m};
    gy    = {1'b0, gy_p} - {1'b0, gy_m};
    ax    = gx[10] ? 10'(-gx) : gx[9:0];
    ay    = gy[10] ? 10'(-gy) : gy[9:0];
    mag   = {1'b0, ax} + {1'b0, ay};
    sobel = (mag > 11'(PIX_MAX)) ? PIX_MAX : mag[PIX_W-1:0];
  end

  rpfs_res_t res;
  logic      x_ge1, x_ge2, y_ge1, y_ge2;
  logic      nores;

  always_comb begin
    x_ge1 = (s1_x_q != '0);
    x_ge2 = (s1_x_q > CW'(1));
    y_ge1 = (s1_y_q != '0);
    y_ge2 = (s1_y_q > RW'(1));

    res.red     = s1_r_q;
    res.green   = s1_g_q;
    res.blue    = s1_b_q;
    res.col     = COORD_W'(s1_x_q);
    res.row     = COORD_W'(s1_y_q);
    res.shifted = 1'b0;
    res.mask    = RES_MAIN;
    res.eof     = s1_lc_q && s1_lr_q;

    case (mode_q)
      MODE_RED: begin
        res.green = '0;
        res.blue  = '0;
      end
      MODE_GREEN: begin
        res.red  = '0;
        res.blue = '0;
      end
      MODE_BLUE: begin
        res.red   = '0;
        res.green = '0;
      end
      MODE_GRAY: begin
        res.red   = s1_luma_q;
        res.green = s1_luma_q;
        res.blue  = s1_luma_q;
      end
      MODE_BIN: begin
        res.red   = (s1_luma_q >= thr_q) ? PIX_MAX : '0;
        res.green = res.red;
        res.blue  = res.red;
      end
      MODE_SOBEL: begin
        res.red     = (x_ge2 && y_ge2) ? sobel : '0;
        res.green   = res.red;
        res.blue    = res.red;
        res.shifted = 1'b1;
        res.mask    = ((x_ge1 && y_ge1) ? RES_MAIN : '0)
                    | ((s1_lr_q && x_ge1) ? RES_LEFT : '0)
                    | ((s1_lc_q && y_ge1) ? RES_UP : '0)
                    | ((s1_lc_q && s1_lr_q) ? RES_CORNER : '0);
      end
      default: begin
      end
    endcase
  end

  assign nores         = (res.mask == '0);
  assign s1_adv        = s1_v_q && (emit_free || nores);
  assign s_axis_tready = !s1_v_q || s1_adv;
  assign acc           = s_axis_tvalid && s_axis_tready;

  always_comb begin
    s1_v_d = s1_v_q;
    if (acc) begin
      s1_v_d = 1'b1;
    end else if (s1_adv) begin
      s1_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
    end
  end

  rpfs_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (s1_adv && !nores),
    .res_i         (res),
    .free_o        (emit_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  `RPFS_ASSERT_NEXT(a_row_advance, clk_i, rst_ni, acc && lc0 && !lr0, (col_q == '0) && (row_q == $past(y0) + RW'(1)), "row did not advance after the last column")
  `RPFS_ASSERT_IMPLY(a_nores_only_sobel, clk_i, rst_ni, s1_v_q && nores, mode_q == MODE_SOBEL, "pixel without result outside edge mode")
  `RPFS_ASSERT_IMPLY(a_eof_on_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, m_axis_tuser, "frame end not on the last word of a pixel")

endmodule
`default_nettype wire

// ===== sv/rpfs_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none
module rpfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// ===== sv/rpfs_emit.sv =====
// Output stage that sends the one to four result words of a pixel in order.
`default_nettype none
module rpfs_emit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  rpfs_pkg::rpfs_res_t          res_i,
  output logic                         free_o,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // red[7:0], green[15:8], blue[23:16], col[34:24], row[45:35], zero pad
  output logic [rpfs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                         m_axis_tlast,   // end of frame
  output logic                         m_axis_tuser    // last word of the pixel
);
  import rpfs_pkg::*;

  logic              v_q, v_d;
  rpfs_res_t         r_q;
  logic [RES_N-1:0]  low;
  logic [RES_N-1:0]  rest;
  logic              last;
  logic              fire;
  logic [PIX_W-1:0]  red, green, blue;
  logic [COORD_W-1:0] col, row;

  assign low  = r_q.mask & (~r_q.mask + RES_N'(1));
  assign rest = r_q.mask & ~low;
  assign last = (rest == '0);
  assign fire = v_q && m_axis_tready;
  assign free_o = !v_q || (fire && last);

  always_comb begin
    v_d = v_q;
    if (load_i) begin
      v_d = 1'b1;
    end else if (fire && last) begin
      v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      r_q <= res_i;
    end else if (fire) begin
      r_q.mask <= rest;
    end
  end

  always_comb begin
    red   = '0;
    green = '0;
    blue  = '0;
    col   = r_q.col;
    row   = r_q.row;
    case (low)
      RES_MAIN: begin
        red   = r_q.red;
        green = r_q.green;
        blue  = r_q.blue;
        if (r_q.shifted) begin
          col = r_q.col - COORD_W'(1);
          row = r_q.row - COORD_W'(1);
        end
      end
      RES_LEFT: begin
        col = r_q.col - COORD_W'(1);
      end
      RES_UP: begin
        row = r_q.row - COORD_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = v_q;
  assign m_axis_tdata  = {2'b00, row, col, blue, green, red};
  assign m_axis_tlast  = r_q.eof && last;
  assign m_axis_tuser  = last;
endmodule
`default_nettype wire

// ===== tb/sv/rgb_pixel_filter_with_sobel_checker.sv =====
// Checker that predicts every filtered word of the pixel filter and compares it on arrival.
module rgb_pixel_filter_with_sobel_checker
  import rpfs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [OUT_DATA_W-1:0] out_data_i,
  input  logic                  out_last_i,
  input  logic                  out_user_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int unsigned LINE_LEN  = DEF_MAX_WIDTH;
  localparam int unsigned ROW_LIMIT = DEF_MAX_HEIGHT;
  localparam int unsigned WEIGHT_R  = 77;
  localparam int unsigned WEIGHT_G  = 150;
  localparam int unsigned WEIGHT_B  = 29;

  typedef struct packed {
    logic [PIX_W-1:0]   red;
    logic [PIX_W-1:0]   green;
    logic [PIX_W-1:0]   blue;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               item_end;
    logic               frame_end;
  } filtered_word_t;

  logic [PIX_W-1:0]  luma_rows [2*LINE_LEN];
  logic [PIX_W-1:0]  luma_win [9];
  int unsigned       col_cnt;
  int unsigned       row_cnt;
  logic [MODE_W-1:0] mode_q;
  logic [PIX_W-1:0]  thresh_q;
  logic [CFG_W-1:0]  width_q;
  logic [CFG_W-1:0]  height_q;

  filtered_word_t expected_words [$];
  filtered_word_t seen;
  filtered_word_t want;
  int mismatches = 0;
  int waiting = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting;

  initial begin
    foreach (luma_rows[i]) luma_rows[i] = '0;
  end

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned top);
    if (v == '0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic filtered_word_t make_word(input logic [PIX_W-1:0] r,
                                               input logic [PIX_W-1:0] g,
                                               input logic [PIX_W-1:0] b,
                                               input int unsigned col,
                                               input int unsigned row);
    filtered_word_t fw;
    fw.red       = r;
    fw.green     = g;
    fw.blue      = b;
    fw.col       = col[COORD_W-1:0];
    fw.row       = row[COORD_W-1:0];
    fw.item_end  = 1'b0;
    fw.frame_end = 1'b0;
    return fw;
  endfunction

  function automatic logic [PIX_W-1:0] edge_strength();
    int px [9];
    int gx;
    int gy;
    int sum;
    foreach (px[k]) px[k] = int'(luma_win[k]);
    gx = (px[2] + 2 * px[5] + px[8]) - (px[0] + 2 * px[3] + px[6]);
    gy = (px[6] + 2 * px[7] + px[8]) - (px[0] + 2 * px[1] + px[2]);
    if (gx < 0) gx = -gx;
    if (gy < 0) gy = -gy;
    sum = gx + gy;
    if (sum > 255) sum = 255;
    return PIX_W'(sum);
  endfunction

  task automatic predict_pixel(input logic [IN_DATA_W-1:0] word);
    int unsigned r;
    int unsigned g;
    int unsigned b;
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned y;
    int unsigned luma;
    int unsigned par;
    logic [PIX_W-1:0] v;
    bit last_col;
    bit last_row;
    filtered_word_t batch [$];
    r = word[PIX_W-1:0];
    g = word[2*PIX_W-1:PIX_W];
    b = word[3*PIX_W-1:2*PIX_W];
    w = clamp_dim(width_q, LINE_LEN);
    h = clamp_dim(height_q, ROW_LIMIT);
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    x = col_cnt;
    y = row_cnt;
    last_col = (x == w - 1);
    last_row = (y == h - 1);

    // The line stores and the window follow the luma stream in every mode.
    luma = (r * WEIGHT_R + g * WEIGHT_G + b * WEIGHT_B) >> 8;
    par = y & 1;
    for (int k = 0; k < 3; k++) begin
      luma_win[3*k]   = luma_win[3*k+1];
      luma_win[3*k+1] = luma_win[3*k+2];
    end
    luma_win[2] = luma_rows[par * LINE_LEN + x];
    luma_win[5] = luma_rows[(par ^ 1) * LINE_LEN + x];
    luma_win[8] = PIX_W'(luma);
    luma_rows[par * LINE_LEN + x] = PIX_W'(luma);

    case (mode_q)
      MODE_RED:   batch.push_back(make_word(PIX_W'(r), '0, '0, x, y));
      MODE_GREEN: batch.push_back(make_word('0, PIX_W'(g), '0, x, y));
      MODE_BLUE:  batch.push_back(make_word('0, '0, PIX_W'(b), x, y));
      MODE_GRAY:  batch.push_back(make_word(PIX_W'(luma), PIX_W'(luma), PIX_W'(luma), x, y));
      MODE_BIN: begin
        v = (luma >= thresh_q) ? PIX_MAX : '0;
        batch.push_back(make_word(v, v, v, x, y));
      end
      MODE_SOBEL: begin
        if (y >= 1 && x >= 1) begin
          v = (x >= 2 && y >= 2) ? edge_strength() : '0;
          batch.push_back(make_word(v, v, v, x - 1, y - 1));
        end
        if (last_row && x >= 1) batch.push_back(make_word('0, '0, '0, x - 1, y));
        if (last_col && y >= 1) batch.push_back(make_word('0, '0, '0, x, y - 1));
        if (last_col && last_row) batch.push_back(make_word('0, '0, '0, x, y));
      end
      default:    batch.push_back(make_word(PIX_W'(r), PIX_W'(g), PIX_W'(b), x, y));
    endcase

    if (batch.size() > 0) begin
      batch[batch.size()-1].item_end = 1'b1;
      if (last_col && last_row) batch[batch.size()-1].frame_end = 1'b1;
    end
    foreach (batch[k]) begin
      expected_words.push_back(batch[k]);
      waiting++;
    end

    if (last_col) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : y + 1;
    end else begin
      col_cnt = x + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   = RST_MODE;
      thresh_q = RST_THRESH;
      width_q  = RST_WIDTH;
      height_q = RST_HEIGHT;
      col_cnt  = 0;
      row_cnt  = 0;
      foreach (luma_win[k]) luma_win[k] = '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE:   mode_q   = cfg_data_i[MODE_W-1:0];
          REG_THRESH: thresh_q = cfg_data_i[PIX_W-1:0];
          REG_WIDTH:  width_q  = cfg_data_i;
          REG_HEIGHT: height_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_pixel(in_data_i);
      if (out_valid_i && out_ready_i) begin
        seen.red       = out_data_i[PIX_W-1:0];
        seen.green     = out_data_i[2*PIX_W-1:PIX_W];
        seen.blue      = out_data_i[3*PIX_W-1:2*PIX_W];
        seen.col       = out_data_i[3*PIX_W+COORD_W-1:3*PIX_W];
        seen.row       = out_data_i[3*PIX_W+2*COORD_W-1:3*PIX_W+COORD_W];
        seen.item_end  = out_user_i;
        seen.frame_end = out_last_i;
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: word with nothing expected: r=%0d g=%0d b=%0d col=%0d row=%0d last=%b eof=%b",
                   $time, seen.red, seen.green, seen.blue, seen.col, seen.row,
                   seen.item_end, seen.frame_end);
        end else begin
          want = expected_words.pop_front();
          waiting--;
          if (seen !== want) begin
            mismatches++;
            $display({"%0t: word mismatch, expected r=%0d g=%0d b=%0d col=%0d row=%0d ",
                      "last=%b eof=%b, actual r=%0d g=%0d b=%0d col=%0d row=%0d last=%b eof=%b"},
                     $time, want.red, want.green, want.blue, want.col, want.row,
                     want.item_end, want.frame_end, seen.red, seen.green, seen.blue,
                     seen.col, seen.row, seen.item_end, seen.frame_end);
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/rgb_pixel_filter_with_sobel_top_tb.sv =====
// Testbench top for the pixel filter: pixel stimulus, register writes, receiver stalls and verdict.
module rgb_pixel_filter_with_sobel_top_tb;
  import rpfs_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam int          DRAIN_CYCLES      = 8;
  localparam int          LONG_STALL_CYCLES = 300;
  localparam int          RANDOM_ITEMS      = 250;
  localparam int          PREFILL_WIDTH     = 32;
  localparam int unsigned RUN_LIMIT         = 4_000_000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_W-1:0]      cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;

  bit long_stall_req;
  bit long_stall_active;
  int fail_count;
  int pending;
  int random_items;

  always #1 clk_i = ~clk_i;

  rgb_pixel_filter_with_sobel_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  rgb_pixel_filter_with_sobel_checker filter_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .out_last_i   (m_axis_tlast),
    .out_user_i   (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic logic [IN_DATA_W-1:0] rand_pixel();
    logic [PIX_W-1:0] ch [3];
    foreach (ch[k]) begin
      case ($urandom_range(0, 7))
        0:       ch[k] = '0;
        1:       ch[k] = '1;
        default: ch[k] = PIX_W'($urandom);
      endcase
    end
    return {ch[2], ch[1], ch[0]};
  endfunction

  task automatic push_pixel(input logic [IN_DATA_W-1:0] px);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_pixels(input int count);
    int burst;
    int gap;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      burst--;
      push_pixel(rand_pixel());
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic settle();
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    #(RUN_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: ready pattern of its own, plus one long hold-off on request.
  initial begin
    bit stalled_once;
    stalled_once      = 1'b0;
    m_axis_tready     = 1'b0;
    long_stall_active = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (long_stall_req && !stalled_once) begin
        stalled_once      = 1'b1;
        long_stall_active = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_STALL_CYCLES) @(negedge clk_i);
        long_stall_active = 1'b0;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(negedge clk_i);
          end
          1: begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk_i);
          end
          default: begin
            repeat ($urandom_range(4, 30)) begin
              m_axis_tready <= 1'($urandom_range(0, 1));
              @(negedge clk_i);
            end
          end
        endcase
      end
    end
  end

  initial begin
    logic [MODE_W-1:0] plain_modes [5];
    logic [MODE_W-1:0] any_modes [8];
    logic [CFG_W-1:0]  odd_widths [2];
    logic [CFG_W-1:0]  odd_sizes [4];
    logic [MODE_W-1:0] pick;
    int w;
    int h;
    int count;
    plain_modes = '{MODE_COPY, MODE_RED, MODE_GREEN, MODE_BLUE, MODE_UNUSED};
    any_modes   = '{MODE_COPY, MODE_RED, MODE_GREEN, MODE_BLUE,
                    MODE_GRAY, MODE_BIN, MODE_SOBEL, MODE_UNUSED};
    odd_widths  = '{12'd0, 12'd1};
    odd_sizes   = '{12'd0, 12'd1, 12'd2048, 12'd4095};
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    long_stall_req = 1'b0;
    random_items   = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Register defaults: gray mode on a 640 x 480 frame.
    push_pixel(24'h000000);
    push_pixel(24'hFFFFFF);
    push_pixel(24'h0000FF);
    push_pixel(24'hFF0000);
    s_axis_tvalid <= 1'b0;
    settle();

    // Two rows fill every line store column that later frames reach; the four
    // pixels above already wrote columns 0 to 3 of row 0.
    write_reg(REG_WIDTH, CFG_W'(PREFILL_WIDTH));
    write_reg(REG_HEIGHT, 12'd2);
    send_pixels(2 * PREFILL_WIDTH - 4);
    settle();

    // Binary at the reset threshold, then at both threshold extremes.
    write_reg(REG_MODE, MODE_BIN);
    push_pixel(24'h808080);
    push_pixel(24'h7F7F7F);
    push_pixel(24'hFFFFFF);
    s_axis_tvalid <= 1'b0;
    settle();
    write_reg(REG_THRESH, 12'd255);
    push_pixel(24'hFFFFFF);
    push_pixel(24'hFEFEFE);
    s_axis_tvalid <= 1'b0;
    settle();
    write_reg(REG_THRESH, 12'd0);
    push_pixel(24'h000000);
    s_axis_tvalid <= 1'b0;
    settle();

    // Shrinking to 1 x 1 mid-row restarts the frame; each pixel is then a whole frame.
    write_reg(REG_WIDTH, 12'd1);
    write_reg(REG_HEIGHT, 12'd1);
    foreach (plain_modes[k]) begin
      settle();
      write_reg(REG_MODE, plain_modes[k]);
      push_pixel(rand_pixel());
      s_axis_tvalid <= 1'b0;
    end
    settle();

    // Smallest frame with an interior; a bright right column saturates the edge.
    write_reg(REG_MODE, MODE_SOBEL);
    write_reg(REG_WIDTH, 12'd3);
    write_reg(REG_HEIGHT, 12'd3);
    for (int i = 0; i < 9; i++) push_pixel((i % 3 == 2) ? 24'hFFFFFF : 24'h000000);
    s_axis_tvalid <= 1'b0;
    settle();

    // Out-of-range sizes: width 0 acts as 1, height 4095 as the tallest frame.
    write_reg(REG_WIDTH, 12'd0);
    write_reg(REG_HEIGHT, 12'd4095);
    send_pixels(40);
    settle();

    // Width 4095 acts as the widest row and height 0 as a single row.
    write_reg(REG_WIDTH, 12'd4095);
    write_reg(REG_HEIGHT, 12'd0);
    send_pixels(20);
    settle();

    // Long receiver hold-off while the sender keeps offering words.
    write_reg(REG_MODE, MODE_COPY);
    write_reg(REG_WIDTH, 12'd16);
    write_reg(REG_HEIGHT, 12'd4);
    long_stall_req = 1'b1;
    wait (long_stall_active);
    send_pixels(64);
    settle();

    while (random_items < RANDOM_ITEMS) begin
      pick = ($urandom_range(0, 9) < 4) ? MODE_SOBEL : any_modes[$urandom_range(0, 7)];
      write_reg(REG_MODE, pick);
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0:       write_reg(REG_THRESH, 12'd0);
          1:       write_reg(REG_THRESH, 12'd255);
          default: write_reg(REG_THRESH, CFG_W'($urandom_range(0, 255)));
        endcase
      end
      if ($urandom_range(0, 7) == 0) begin
        write_reg(REG_WIDTH, odd_widths[$urandom_range(0, 1)]);
        write_reg(REG_HEIGHT, odd_sizes[$urandom_range(0, 3)]);
        count = $urandom_range(1, 40);
      end else begin
        w = $urandom_range(1, 7);
        h = $urandom_range(1, 5);
        if ($urandom_range(0, 2) != 0) begin
          write_reg(REG_WIDTH, CFG_W'(w));
          write_reg(REG_HEIGHT, CFG_W'(h));
        end
        count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : 2 * w * h;
      end
      send_pixels(count);
      random_items += count;
      settle();
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/rpfs_pkg.sv
sv/rpfs_ram.sv
sv/rpfs_emit.sv
sv/rgb_pixel_filter_with_sobel_top.sv
tb/sv/rgb_pixel_filter_with_sobel_checker.sv
tb/sv/rgb_pixel_filter_with_sobel_top_tb.sv
